// File: src/pts_pkg.sv
package pts_pkg;

    localparam int unsigned TaskW     = 4;
    localparam int unsigned NumTasks  = 16;
    localparam int unsigned MaxTasks  = 15;
    localparam int unsigned MaxPrio   = 15;
    localparam int unsigned NumPrio   = 16;
    localparam int unsigned NumSems   = 4;
    localparam int unsigned SemW      = 2;
    localparam int unsigned InDataW   = 88;
    localparam int unsigned OutDataW  = 48;
    localparam int unsigned PaddrW    = 3;

    localparam logic [PaddrW-1:0] AddrMinStack = 3'd0;
    localparam logic [15:0]       MinStackRst  = 16'd64;

    typedef enum logic [3:0] {
        OP_CREATE      = 4'd0,
        OP_SUSPEND     = 4'd1,
        OP_RESUME      = 4'd2,
        OP_DELAY       = 4'd3,
        OP_TICK        = 4'd4,
        OP_SWITCH      = 4'd5,
        OP_START       = 4'd6,
        OP_SEM_SET     = 4'd7,
        OP_SEM_WAIT    = 4'd8,
        OP_SEM_RELEASE = 4'd9
    } op_t;

    typedef struct packed {
        logic latch;
        logic exec;
        logic tick_init;
        logic tick_step;
        logic scan_init;
        logic scan_step;
        logic ram_read;
        logic load_out;
    } cmd_t;

    typedef struct packed {
        logic is_tick;
        logic tick_last;
        logic scan_last;
        logic out_busy;
    } status_t;

endpackage

// File: src/pts_ram.sv
module pts_ram #(
    parameter int unsigned WIDTH = 32,
    parameter int unsigned DEPTH = 16
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// File: src/pts_ctrl.sv
module pts_ctrl (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  pts_pkg::status_t status,
    output pts_pkg::cmd_t    cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_EXEC,
        S_TICK,
        S_SCAN,
        S_READ,
        S_FINISH
    } state_t;

    state_t state_reg;
    state_t state_next;

    always_comb
    begin
        cmd        = '0;
        state_next = state_reg;
        in_ready   = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.latch  = 1'b1;
                    state_next = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.is_tick)
                begin
                    cmd.tick_init = 1'b1;
                    state_next    = S_TICK;
                end
                else
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_TICK:
            begin
                cmd.tick_step = 1'b1;
                if (status.tick_last)
                begin
                    cmd.scan_init = 1'b1;
                    state_next    = S_SCAN;
                end
            end
            S_SCAN:
            begin
                cmd.scan_step = 1'b1;
                if (status.scan_last)
                begin
                    state_next = S_READ;
                end
            end
            S_READ:
            begin
                cmd.ram_read = 1'b1;
                state_next   = S_FINISH;
            end
            S_FINISH:
            begin
                if (!status.out_busy)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// File: src/pts_datapath.sv
module pts_datapath (
    input  logic                                 clk,
    input  logic                                 rst_n,
    input  pts_pkg::cmd_t                        cmd,
    output pts_pkg::status_t                     status,
    input  logic [pts_pkg::InDataW-1:0]          in_data,
    output logic [pts_pkg::OutDataW-1:0]         out_data,
    output logic                                 out_valid,
    input  logic                                 out_ready,
    input  logic                                 cfg_we,
    input  logic [15:0]                          cfg_wdata,
    output logic [15:0]                          min_stack
);

    localparam int unsigned TW = pts_pkg::TaskW;

    pts_pkg::op_t                op_reg;
    logic [TW-1:0]               tid_reg;
    logic [TW-1:0]               prio_reg;
    logic [15:0]                 ticks_reg;
    logic [31:0]                 sp_reg;
    logic [15:0]                 size_reg;
    logic [pts_pkg::SemW-1:0]    si_reg;
    logic [7:0]                  scount_reg;

    logic [15:0]                 min_stack_reg;
    logic                        ready_reg [pts_pkg::NumTasks];
    logic [15:0]                 delay_reg [pts_pkg::NumTasks];
    logic [TW-1:0]               tap_reg   [pts_pkg::NumPrio];
    logic [7:0]                  semv_reg  [pts_pkg::NumSems];
    logic [TW-1:0]               semw_reg  [pts_pkg::NumSems];
    logic [TW-1:0]               created_reg;
    logic [TW-1:0]               running_reg;

    logic [TW-1:0]               idx_reg;
    logic [TW-1:0]               sel_reg;
    logic                        found_reg;
    logic                        sw_reg;
    logic                        acc_reg;
    logic                        out_valid_reg;
    logic [pts_pkg::OutDataW-1:0] out_data_reg;

    logic                        create_ok;
    logic [TW-1:0]               new_task;
    logic                        ram_we;
    logic [TW-1:0]               ram_waddr;
    logic [31:0]                 ram_rdata;
    logic [TW-1:0]               cand;
    logic [31:0]                 new_sp;
    logic [TW-1:0]               waiter;

    assign create_ok = (size_reg >= min_stack_reg) &&
                       ({4'd0, created_reg} < 8'(pts_pkg::MaxTasks));
    assign new_task  = created_reg + 1'b1;
    assign cand      = tap_reg[idx_reg];
    assign waiter    = semw_reg[si_reg];

    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = running_reg;
        if (cmd.exec && op_reg == pts_pkg::OP_CREATE && create_ok)
        begin
            ram_we    = 1'b1;
            ram_waddr = new_task;
        end
        else if (cmd.exec && op_reg == pts_pkg::OP_SWITCH)
        begin
            ram_we = 1'b1;
        end
    end

    pts_ram #(
        .WIDTH (32),
        .DEPTH (pts_pkg::NumTasks)
    ) u_stack_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (sp_reg),
        .re    (cmd.ram_read),
        .raddr (sel_reg),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk)
    begin
        if (cmd.latch)
        begin
            op_reg     <= pts_pkg::op_t'(in_data[3:0]);
            tid_reg    <= in_data[7:4];
            prio_reg   <= in_data[11:8];
            ticks_reg  <= in_data[27:12];
            sp_reg     <= in_data[59:28];
            size_reg   <= in_data[75:60];
            si_reg     <= in_data[77:76];
            scount_reg <= in_data[85:78];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            min_stack_reg <= pts_pkg::MinStackRst;
            created_reg   <= '0;
            running_reg   <= '0;
            idx_reg       <= '0;
            sel_reg       <= '0;
            found_reg     <= 1'b0;
            sw_reg        <= 1'b0;
            acc_reg       <= 1'b1;
            for (int i = 0; i < pts_pkg::NumTasks; i++)
            begin
                ready_reg[i] <= 1'b0;
                delay_reg[i] <= '0;
            end
            for (int i = 0; i < pts_pkg::NumPrio; i++)
            begin
                tap_reg[i] <= '0;
            end
            for (int i = 0; i < pts_pkg::NumSems; i++)
            begin
                semv_reg[i] <= '0;
                semw_reg[i] <= '0;
            end
        end
        else
        begin
            if (cfg_we)
            begin
                min_stack_reg <= cfg_wdata;
            end
            if (cmd.exec)
            begin
                sw_reg  <= 1'b0;
                acc_reg <= 1'b1;
                case (op_reg)
                    pts_pkg::OP_CREATE:
                    begin
                        if (create_ok)
                        begin
                            created_reg         <= new_task;
                            ready_reg[new_task] <= 1'b1;
                            delay_reg[new_task] <= '0;
                            tap_reg[prio_reg]   <= new_task;
                        end
                        else
                        begin
                            acc_reg <= 1'b0;
                        end
                    end
                    pts_pkg::OP_SUSPEND:
                    begin
                        ready_reg[tid_reg] <= 1'b0;
                        sw_reg             <= 1'b1;
                    end
                    pts_pkg::OP_RESUME:
                    begin
                        ready_reg[tid_reg] <= 1'b1;
                        sw_reg             <= 1'b1;
                    end
                    pts_pkg::OP_DELAY:
                    begin
                        if (ticks_reg != '0)
                        begin
                            delay_reg[running_reg] <= ticks_reg;
                            ready_reg[running_reg] <= 1'b0;
                            sw_reg                 <= 1'b1;
                        end
                    end
                    pts_pkg::OP_START:
                    begin
                        sw_reg <= 1'b1;
                    end
                    pts_pkg::OP_SEM_SET:
                    begin
                        semv_reg[si_reg] <= scount_reg;
                        semw_reg[si_reg] <= '0;
                    end
                    pts_pkg::OP_SEM_WAIT:
                    begin
                        if (semv_reg[si_reg] != '0)
                        begin
                            semv_reg[si_reg] <= semv_reg[si_reg] - 1'b1;
                        end
                        else
                        begin
                            ready_reg[running_reg] <= 1'b0;
                            semw_reg[si_reg]       <= running_reg;
                            sw_reg                 <= 1'b1;
                        end
                    end
                    pts_pkg::OP_SEM_RELEASE:
                    begin
                        if (waiter != '0)
                        begin
                            ready_reg[waiter] <= 1'b1;
                            semw_reg[si_reg]  <= '0;
                        end
                        else if (semv_reg[si_reg] != 8'hff)
                        begin
                            semv_reg[si_reg] <= semv_reg[si_reg] + 1'b1;
                        end
                        sw_reg <= 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            if (cmd.tick_step && idx_reg <= created_reg && delay_reg[idx_reg] != '0)
            begin
                delay_reg[idx_reg] <= delay_reg[idx_reg] - 1'b1;
                if (delay_reg[idx_reg] == 16'd1)
                begin
                    ready_reg[idx_reg] <= 1'b1;
                end
            end
            if (cmd.scan_step)
            begin
                if (!found_reg && idx_reg != '0 && cand != '0 && ready_reg[cand])
                begin
                    sel_reg   <= cand;
                    found_reg <= 1'b1;
                end
                else if (!found_reg && idx_reg == '0)
                begin
                    sel_reg <= cand;
                end
                idx_reg <= idx_reg - 1'b1;
            end
            priority if (cmd.scan_init)
            begin
                idx_reg   <= TW'(pts_pkg::MaxPrio);
                found_reg <= 1'b0;
                sel_reg   <= '0;
            end
            else if (cmd.tick_init)
            begin
                idx_reg <= TW'(1);
            end
            else if (cmd.tick_step)
            begin
                idx_reg <= idx_reg + 1'b1;
            end
            if (cmd.ram_read &&
                (op_reg == pts_pkg::OP_SWITCH || op_reg == pts_pkg::OP_START))
            begin
                running_reg <= sel_reg;
            end
        end
    end

    // output register, one result per item
    assign new_sp = (op_reg == pts_pkg::OP_SWITCH || op_reg == pts_pkg::OP_START) ?
                    ram_rdata : 32'd0;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.load_out)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load_out)
        begin
            out_data_reg <= {6'd0, acc_reg, sw_reg, new_sp, running_reg, sel_reg};
        end
    end

    assign out_data         = out_data_reg;
    assign out_valid        = out_valid_reg;
    assign min_stack        = min_stack_reg;
    assign status.is_tick   = (op_reg == pts_pkg::OP_TICK);
    assign status.tick_last = (idx_reg == TW'(pts_pkg::MaxTasks));
    assign status.scan_last = (idx_reg == '0);
    assign status.out_busy  = out_valid_reg && !out_ready;

endmodule

// File: src/priority_task_scheduler_top.sv
// Fixed-priority task scheduler. One operation enters on the slave stream and
// gives exactly one result on the master stream. Each item passes through these
// steps in order: the accepting state, applying the operation, on a tick a walk
// of the delay counters over tasks 1 to 15, the priority scan from 15 down to 0,
// a read of the saved stack pointer memory, and loading the output register,
// which waits while the output is stalled. A new item is taken once the previous
// one has reached the output register. min_stack_size sits at byte address 0 of
// the configuration port.
module priority_task_scheduler_top (
    input  logic                              clk,
    input  logic                              rst_n,
    // op[3:0], task_id[7:4], priority_req[11:8], ticks[27:12], stack_ptr[59:28],
    // stack_size[75:60], sem_index[77:76], sem_count[85:78]
    input  logic [pts_pkg::InDataW-1:0]       s_tdata,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // selected_task[3:0], current_task[7:4], new_stack_ptr[39:8],
    // switch_request[40], accepted[41]
    output logic [pts_pkg::OutDataW-1:0]      m_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    input  logic                              psel,
    input  logic                              penable,
    input  logic                              pwrite,
    input  logic [pts_pkg::PaddrW-1:0]        paddr,
    input  logic [31:0]                       pwdata,
    output logic [31:0]                       prdata,
    output logic                              pready
);

    pts_pkg::cmd_t    cmd;
    pts_pkg::status_t status;
    logic             cfg_we;
    logic [15:0]      min_stack;

    assign pready = 1'b1;
    assign cfg_we = psel && penable && pwrite && pready && (paddr == pts_pkg::AddrMinStack);
    assign prdata = (paddr == pts_pkg::AddrMinStack) ? {16'd0, min_stack} : 32'd0;

    pts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .in_ready (s_tready),
        .status   (status),
        .cmd      (cmd)
    );

    pts_datapath u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .status    (status),
        .in_data   (s_tdata),
        .out_data  (m_tdata),
        .out_valid (m_tvalid),
        .out_ready (m_tready),
        .cfg_we    (cfg_we),
        .cfg_wdata (pwdata[15:0]),
        .min_stack (min_stack)
    );

endmodule

// File: src/pts_checker.sv
module pts_checker (
    input logic                          clk,
    input logic                          rst_n,
    input logic                          s_tvalid,
    input logic                          s_tready,
    input logic [pts_pkg::OutDataW-1:0]  m_tdata,
    input logic                          m_tvalid,
    input logic                          m_tready,
    input logic                          pready
);

    // stalled result holds
    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("stalled result changed");

    // one item at a time
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready |=> !s_tready)
        else $error("input taken while busy");

    // no result can appear right after a transfer in
    assert property (@(posedge clk) disable iff (!rst_n)
        s_tvalid && s_tready && !m_tvalid |=> !m_tvalid)
        else $error("result without work");

    assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> m_tdata[pts_pkg::OutDataW-1:42] == '0)
        else $error("padding bits set");

    assert property (@(posedge clk) disable iff (!rst_n) pready)
        else $error("pready low");

endmodule

bind priority_task_scheduler_top pts_checker u_pts_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tdata  (m_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .pready   (pready)
);

// File: sim/pts_checker.sv
`timescale 1ns / 1ps

module pts_scoreboard (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic [pts_pkg::InDataW-1:0]  s_tdata,
    input  logic                         s_tvalid,
    input  logic                         s_tready,
    input  logic [pts_pkg::OutDataW-1:0] m_tdata,
    input  logic                         m_tvalid,
    input  logic                         m_tready,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [pts_pkg::PaddrW-1:0]   paddr,
    input  logic [31:0]                  pwdata,
    input  logic                         pready,
    output int                           fail_count,
    output int                           pending_count,
    output int                           ops_done
);

    typedef struct packed {
        logic [1:0]  pad;
        logic [7:0]  sem_count;
        logic [1:0]  sem_index;
        logic [15:0] stack_size;
        logic [31:0] stack_ptr;
        logic [15:0] ticks;
        logic [3:0]  prio;
        logic [3:0]  task_id;
        logic [3:0]  op;
    } sched_op_t;

    typedef struct packed {
        logic [5:0]  pad;
        logic        accepted;
        logic        switch_req;
        logic [31:0] new_sp;
        logic [3:0]  current;
        logic [3:0]  selected;
    } sched_res_t;

    logic [15:0]               min_stack;
    logic                      ready_flag [pts_pkg::NumTasks];
    logic [15:0]               delay_cnt  [pts_pkg::NumTasks];
    logic [31:0]               stack_save [pts_pkg::NumTasks];
    logic [pts_pkg::TaskW-1:0] prio_map   [pts_pkg::NumPrio];
    logic [pts_pkg::TaskW-1:0] n_created;
    logic [pts_pkg::TaskW-1:0] running;
    logic [7:0]                sem_cnt    [pts_pkg::NumSems];
    logic [pts_pkg::TaskW-1:0] sem_wait_task [pts_pkg::NumSems];
    sched_res_t                expected_results [$];

    function automatic logic [pts_pkg::TaskW-1:0] highest_ready();
        for (int p = pts_pkg::MaxPrio; p > 0; p--)
        begin
            if (prio_map[p] != 0 && ready_flag[prio_map[p]])
                return prio_map[p];
        end
        return prio_map[0];
    endfunction

    task automatic run_op(input sched_op_t w);
        sched_res_t r;
        int si;
        r = '0;
        r.accepted = 1'b1;
        si = w.sem_index;
        case (w.op)
            pts_pkg::OP_CREATE:
            begin
                if (w.stack_size < min_stack || n_created >= pts_pkg::MaxTasks
                    || w.prio > pts_pkg::MaxPrio)
                    r.accepted = 1'b0;
                else
                begin
                    n_created = n_created + 1'b1;
                    stack_save[n_created] = w.stack_ptr;
                    ready_flag[n_created] = 1'b1;
                    delay_cnt[n_created] = '0;
                    prio_map[w.prio] = n_created;
                end
            end
            pts_pkg::OP_SUSPEND, pts_pkg::OP_RESUME:
            begin
                ready_flag[w.task_id] = (w.op == pts_pkg::OP_RESUME);
                r.switch_req = 1'b1;
            end
            pts_pkg::OP_DELAY:
            begin
                if (w.ticks != 0)
                begin
                    delay_cnt[running] = w.ticks;
                    ready_flag[running] = 1'b0;
                    r.switch_req = 1'b1;
                end
            end
            pts_pkg::OP_TICK:
            begin
                for (int t = n_created; t > 0; t--)
                begin
                    if (delay_cnt[t] != 0)
                    begin
                        delay_cnt[t] = delay_cnt[t] - 1'b1;
                        if (delay_cnt[t] == 0)
                            ready_flag[t] = 1'b1;
                    end
                end
            end
            pts_pkg::OP_SWITCH:
            begin
                stack_save[running] = w.stack_ptr;
                running = highest_ready();
                r.new_sp = stack_save[running];
            end
            pts_pkg::OP_START:
            begin
                running = highest_ready();
                r.new_sp = stack_save[running];
                r.switch_req = 1'b1;
            end
            pts_pkg::OP_SEM_SET:
            begin
                sem_cnt[si] = w.sem_count;
                sem_wait_task[si] = '0;
            end
            pts_pkg::OP_SEM_WAIT:
            begin
                if (sem_cnt[si] != 0)
                    sem_cnt[si] = sem_cnt[si] - 1'b1;
                else
                begin
                    ready_flag[running] = 1'b0;
                    sem_wait_task[si] = running;
                    r.switch_req = 1'b1;
                end
            end
            pts_pkg::OP_SEM_RELEASE:
            begin
                if (sem_wait_task[si] != 0)
                begin
                    ready_flag[sem_wait_task[si]] = 1'b1;
                    sem_wait_task[si] = '0;
                end
                else if (sem_cnt[si] != 8'hFF)
                    sem_cnt[si] = sem_cnt[si] + 1'b1;
                r.switch_req = 1'b1;
            end
            default:
            begin
            end
        endcase
        r.selected = highest_ready();
        r.current = running;
        expected_results.push_back(r);
    endtask

    initial
    begin
        fail_count = 0;
        ops_done = 0;
        pending_count = 0;
    end

    always @(posedge clk)
    begin
        sched_res_t want;
        sched_res_t got;
        if (!rst_n)
        begin
            min_stack = pts_pkg::MinStackRst;
            for (int i = 0; i < pts_pkg::NumTasks; i++)
            begin
                ready_flag[i] = 1'b0;
                delay_cnt[i] = '0;
                stack_save[i] = '0;
            end
            for (int i = 0; i < pts_pkg::NumPrio; i++)
                prio_map[i] = '0;
            for (int i = 0; i < pts_pkg::NumSems; i++)
            begin
                sem_cnt[i] = '0;
                sem_wait_task[i] = '0;
            end
            n_created = '0;
            running = '0;
            expected_results.delete();
            pending_count = 0;
        end
        else
        begin
            if (psel && penable && pwrite && pready && paddr == pts_pkg::AddrMinStack)
                min_stack = pwdata[15:0];
            if (s_tvalid && s_tready)
                run_op(sched_op_t'(s_tdata));
            if (m_tvalid && m_tready)
            begin
                got = sched_res_t'(m_tdata);
                ops_done++;
                if (expected_results.size() == 0)
                begin
                    fail_count++;
                    if (fail_count <= 10)
                        $display("%0t: result with nothing expected: %h", $realtime, m_tdata);
                end
                else
                begin
                    want = expected_results.pop_front();
                    if (got.selected !== want.selected || got.current !== want.current
                        || got.new_sp !== want.new_sp || got.switch_req !== want.switch_req
                        || got.accepted !== want.accepted)
                    begin
                        fail_count++;
                        if (fail_count <= 10)
                            $display("%0t: mismatch sel %h/%h cur %h/%h sp %h/%h sw %b/%b acc %b/%b",
                                     $realtime, want.selected, got.selected, want.current,
                                     got.current, want.new_sp, got.new_sp, want.switch_req,
                                     got.switch_req, want.accepted, got.accepted);
                    end
                end
            end
            pending_count = expected_results.size();
        end
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 1ps

module tb_top;

    localparam logic [3:0] OpFirstUnused = 4'd10;
    localparam logic [3:0] OpLastUnused  = 4'd15;
    localparam int         DrainCycles   = 80;
    localparam int         LongHold      = 400;

    logic                         clk = 1'b0;
    logic                         rst_n = 1'b0;
    logic [pts_pkg::InDataW-1:0]  s_tdata = '0;
    logic                         s_tvalid = 1'b0;
    logic                         s_tready;
    logic [pts_pkg::OutDataW-1:0] m_tdata;
    logic                         m_tvalid;
    logic                         m_tready = 1'b0;
    logic                         psel = 1'b0;
    logic                         penable = 1'b0;
    logic                         pwrite = 1'b0;
    logic [pts_pkg::PaddrW-1:0]   paddr = '0;
    logic [31:0]                  pwdata = '0;
    logic [31:0]                  prdata;
    logic                         pready;
    logic                         hold_request = 1'b0;
    int                           fail_count;
    int                           pending_count;
    int                           ops_done;
    int                           burst_left = 0;
    logic [15:0]                  cur_min = pts_pkg::MinStackRst;

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    priority_task_scheduler_top DUT (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .prdata(prdata), .pready(pready)
    );

    pts_scoreboard checker_i (
        .clk(clk), .rst_n(rst_n),
        .s_tdata(s_tdata), .s_tvalid(s_tvalid), .s_tready(s_tready),
        .m_tdata(m_tdata), .m_tvalid(m_tvalid), .m_tready(m_tready),
        .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr),
        .pwdata(pwdata), .pready(pready),
        .fail_count(fail_count), .pending_count(pending_count), .ops_done(ops_done)
    );

    function automatic logic [pts_pkg::InDataW-1:0] pack_op(input logic [3:0] op,
        input logic [3:0] tid, input logic [3:0] prio, input logic [15:0] ticks,
        input logic [31:0] sp, input logic [15:0] size, input logic [1:0] si,
        input logic [7:0] sc);
        return {2'b00, sc, si, size, sp, ticks, prio, tid, op};
    endfunction

    // receiver: pattern changes at random, long hold on request
    initial
    begin
        int mode;
        mode = 0;
        forever
        begin
            @(posedge clk);
            if (hold_request)
            begin
                m_tready <= 1'b0;
                repeat (LongHold) @(posedge clk);
                hold_request = 1'b0;
            end
            if ($urandom_range(0, 199) == 0)
                mode = $urandom_range(0, 2);
            case (mode)
                0: m_tready <= 1'b1;
                1: m_tready <= 1'($urandom_range(0, 1));
                default: m_tready <= ($urandom_range(0, 9) == 0);
            endcase
        end
    end

    task automatic send_op(input logic [pts_pkg::InDataW-1:0] w);
        int gap;
        s_tdata <= w;
        s_tvalid <= 1'b1;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        if (burst_left > 0)
            burst_left--;
        else
        begin
            burst_left = $urandom_range(0, 30);
            gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 25);
            if (gap > 0)
            begin
                s_tvalid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
    endtask

    task automatic drain();
        s_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_count != 0)
            @(posedge clk);
        repeat (DrainCycles) @(posedge clk);
    endtask

    task automatic write_min_stack(input logic [15:0] v);
        psel <= 1'b1;
        pwrite <= 1'b1;
        penable <= 1'b0;
        paddr <= pts_pkg::AddrMinStack;
        pwdata <= {16'h0, v};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cur_min = v;
    endtask

    function automatic logic [pts_pkg::InDataW-1:0] random_op();
        logic [3:0]  op;
        logic [15:0] ticks;
        logic [15:0] size;
        logic [7:0]  sc;
        int          pick;
        pick = $urandom_range(0, 99);
        if (pick < 10)
            op = pts_pkg::OP_CREATE;
        else if (pick < 18)
            op = pts_pkg::OP_SUSPEND;
        else if (pick < 26)
            op = pts_pkg::OP_RESUME;
        else if (pick < 34)
            op = pts_pkg::OP_DELAY;
        else if (pick < 50)
            op = pts_pkg::OP_TICK;
        else if (pick < 61)
            op = pts_pkg::OP_SWITCH;
        else if (pick < 66)
            op = pts_pkg::OP_START;
        else if (pick < 74)
            op = pts_pkg::OP_SEM_SET;
        else if (pick < 86)
            op = pts_pkg::OP_SEM_WAIT;
        else if (pick < 97)
            op = pts_pkg::OP_SEM_RELEASE;
        else
            op = 4'($urandom_range(OpFirstUnused, OpLastUnused));
        ticks = ($urandom_range(0, 7) == 0) ? 16'($urandom) : 16'($urandom_range(0, 6));
        if ($urandom_range(0, 2) == 0)
            size = 16'($urandom);
        else if (cur_min > 16'hFF00)
            size = 16'hFFFF;
        else
            size = cur_min + 16'($urandom_range(0, 255));
        sc = ($urandom_range(0, 3) == 0) ? 8'($urandom) : 8'($urandom_range(0, 3));
        return pack_op(op, 4'($urandom), 4'($urandom), ticks, $urandom, size,
                       2'($urandom), sc);
    endfunction

    initial
    begin
        logic [15:0] settings [5];
        settings = '{16'd64, 16'd0, 16'hFFFF, 16'd0, 16'd32};
        settings[3] = 16'($urandom);
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first switch writes the saved stack of task zero
        send_op(pack_op(pts_pkg::OP_SWITCH, 0, 0, 0, 32'h0000_1000, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_CREATE, 0, 3, 0, 32'h1111_0000, 16'd63, 0, 0));
        send_op(pack_op(pts_pkg::OP_CREATE, 0, 0, 0, 32'h0000_0000, 16'd64, 0, 0));
        send_op(pack_op(pts_pkg::OP_CREATE, 0, 15, 0, 32'hFFFF_FFFF, 16'hFFFF, 0, 0));
        send_op(pack_op(pts_pkg::OP_CREATE, 0, 15, 0, 32'h2222_2222, 16'd100, 0, 0));
        send_op(pack_op(pts_pkg::OP_START, 0, 0, 0, 0, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_SUSPEND, 3, 0, 0, 0, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_SWITCH, 0, 0, 0, 32'hA5A5_A5A5, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_RESUME, 3, 0, 0, 0, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_SUSPEND, 15, 0, 0, 0, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_DELAY, 0, 0, 16'd0, 0, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_DELAY, 0, 0, 16'd2, 0, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_SWITCH, 0, 0, 0, 32'h5A5A_5A5A, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_TICK, 0, 0, 0, 0, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_SEM_SET, 0, 0, 0, 0, 0, 2'd3, 8'd0));
        send_op(pack_op(pts_pkg::OP_SEM_WAIT, 0, 0, 0, 0, 0, 2'd3, 0));
        send_op(pack_op(pts_pkg::OP_SEM_RELEASE, 0, 0, 0, 0, 0, 2'd3, 0));
        send_op(pack_op(pts_pkg::OP_SEM_SET, 0, 0, 0, 0, 0, 2'd0, 8'hFF));
        send_op(pack_op(pts_pkg::OP_SEM_RELEASE, 0, 0, 0, 0, 0, 2'd0, 0));
        send_op(pack_op(pts_pkg::OP_SEM_WAIT, 0, 0, 0, 0, 0, 2'd0, 0));
        send_op(pack_op(OpLastUnused, 0, 0, 0, 0, 0, 0, 0));
        send_op(pack_op(pts_pkg::OP_DELAY, 0, 0, 16'hFFFF, 0, 0, 0, 0));

        for (int phase = 0; phase < 5; phase++)
        begin
            drain();
            write_min_stack(settings[phase]);
            for (int n = 0; n < 365; n++)
            begin
                if (n == 100 && phase % 2 == 1)
                    hold_request = 1'b1;
                if (n == 250)
                    drain();
                send_op(random_op());
            end
        end
        drain();
        s_tvalid <= 1'b0;

        $display("covered %0d scheduler operations across %0d min stack settings,",
                 ops_done, 5);
        $display("with bursty input, output stalls and long output holds");
        if (fail_count == 0)
            $display("tb_top OK");
        else
            $display("tb_top NOT OK");
        $finish;
    end

    initial
    begin
        #10_000_000;
        $display("tb_top NOT OK");
        $finish;
    end

endmodule
